[rtl/core/pli_pkg.sv]
// Shared types, codes and constants of the positional list core.
package pli_pkg;

	// Widths of the item fields.
	localparam int OP_W   = 3;
	localparam int VAL_W  = 32;
	localparam int POS_W  = 6;
	localparam int STAT_W = 2;

	// Default number of list cells.
	localparam int DEPTH_DEFAULT = 16;

	typedef logic signed [VAL_W-1:0] elem_t;
	typedef logic [OP_W-1:0]         op_t;
	typedef logic [POS_W-1:0]        pos_t;
	typedef logic [STAT_W-1:0]       status_t;

	// Command codes of the input item.
	localparam op_t OP_INSERT     = 3'd0;
	localparam op_t OP_DEL_FIRST  = 3'd1;
	localparam op_t OP_DEL_AT     = 3'd2;
	localparam op_t OP_DEL_LAST   = 3'd3;
	localparam op_t OP_DISPLAY    = 3'd4;

	// Status codes of the result item.
	localparam status_t ST_OK     = 2'd0;
	localparam status_t ST_BADPOS = 2'd1;
	localparam status_t ST_EMPTY  = 2'd2;
	localparam status_t ST_FULL   = 2'd3;

	// Commands broadcast to every cell of the chain.
	typedef logic [1:0] cell_cmd_t;
	localparam cell_cmd_t CMD_HOLD   = 2'd0;
	localparam cell_cmd_t CMD_INSERT = 2'd1;
	localparam cell_cmd_t CMD_REMOVE = 2'd2;
	localparam cell_cmd_t CMD_ROTATE = 2'd3;

	// Control bundle from the sequencer to the cells.
	typedef struct packed {
		cell_cmd_t cmd;
		pos_t      pos;
		pos_t      last_idx;
	} cell_ctrl_t;

endpackage

[rtl/core/positional_list_insert_delete_core.sv]
// Top level of the positional list core: command sequencer and chain of cells.
// The list lives in a row of DEPTH cells, element k in cell k. Insert and delete
// at a position shift the cells at and beyond the position by one place; delete
// last only lowers the count. Insert and each delete give one status item.
// Display rotates the chain left one place per cycle while the output register
// can take an item and emits cell 0 each time; an empty list gives one empty
// status instead. No new item is accepted until the final element (marked by
// last) has gone into the output register. A one-item output register parts the
// two channels. Operation codes 5 to 7 are accepted and give no result.
module positional_list_insert_delete_core #(
	parameter int DEPTH = pli_pkg::DEPTH_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  pli_pkg::op_t      operation,
	input  pli_pkg::elem_t    value,
	input  pli_pkg::pos_t     position,
	output logic              out_valid,
	input  logic              out_ready,
	output pli_pkg::elem_t    element,
	output pli_pkg::status_t  status,
	output logic              last
);
	import pli_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	logic          busy_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] rem_q;
	logic          out_valid_q;
	elem_t         element_q;
	status_t       status_q;
	logic          last_q;

	logic          slot_free;
	logic          accept;
	logic          step;
	logic [POS_W:0] pos_x;
	logic [POS_W:0] cnt_x;
	logic          empty;
	logic          full;
	logic [CW-1:0] cnt_m1;

	cell_ctrl_t    ctrl;
	elem_t         new_val;
	elem_t         cell_val [DEPTH];

	logic          emit_status;
	status_t       emit_code;
	logic          cnt_inc;
	logic          cnt_dec;
	logic          start_disp;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = !busy_q && slot_free;
	assign accept    = in_valid && in_ready;
	assign step      = busy_q && slot_free;

	assign pos_x  = {1'b0, position};
	assign cnt_x  = (POS_W + 1)'(count_q);
	assign empty  = (count_q == '0);
	assign full   = (count_q == CW'(DEPTH));
	assign cnt_m1 = count_q - CW'(1);

	// Decode the accepted command into a cell command and a status item.
	always_comb begin
		ctrl.cmd      = CMD_HOLD;
		ctrl.pos      = position;
		ctrl.last_idx = POS_W'(cnt_m1);
		new_val       = value;
		emit_status   = 1'b0;
		emit_code     = ST_OK;
		cnt_inc       = 1'b0;
		cnt_dec       = 1'b0;
		start_disp    = 1'b0;
		if (step) begin
			ctrl.cmd = CMD_ROTATE;
			new_val  = cell_val[0];
		end else if (accept) begin
			unique case (operation)
				OP_INSERT: begin
					emit_status = 1'b1;
					if (pos_x > cnt_x) begin
						emit_code = ST_BADPOS;
					end else if (full) begin
						emit_code = ST_FULL;
					end else begin
						ctrl.cmd = CMD_INSERT;
						cnt_inc  = 1'b1;
					end
				end
				OP_DEL_FIRST: begin
					emit_status = 1'b1;
					if (empty) begin
						emit_code = ST_EMPTY;
					end else begin
						ctrl.cmd = CMD_REMOVE;
						ctrl.pos = '0;
						cnt_dec  = 1'b1;
					end
				end
				OP_DEL_AT: begin
					emit_status = 1'b1;
					if (empty) begin
						emit_code = ST_EMPTY;
					end else if (pos_x >= cnt_x) begin
						emit_code = ST_BADPOS;
					end else begin
						ctrl.cmd = CMD_REMOVE;
						cnt_dec  = 1'b1;
					end
				end
				OP_DEL_LAST: begin
					emit_status = 1'b1;
					if (empty) begin
						emit_code = ST_EMPTY;
					end else begin
						cnt_dec = 1'b1;
					end
				end
				OP_DISPLAY: begin
					if (empty) begin
						emit_status = 1'b1;
						emit_code   = ST_EMPTY;
					end else begin
						start_disp = 1'b1;
					end
				end
				default: begin
					emit_status = 1'b0;
				end
			endcase
		end
	end

	// Chain of cells, each seeing its neighbors; the end cells see zero in place of a missing one.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		elem_t left_val;
		elem_t right_val;
		if (i == 0) begin : g_first
			assign left_val = '0;
		end else begin : g_mid_l
			assign left_val = cell_val[i-1];
		end
		if (i == DEPTH - 1) begin : g_end
			assign right_val = '0;
		end else begin : g_mid_r
			assign right_val = cell_val[i+1];
		end
		pli_cell #(
			.INDEX(i)
		) u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.left_val (left_val),
			.right_val(right_val),
			.new_val  (new_val),
			.data     (cell_val[i])
		);
	end

	// Element count and display sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			count_q <= '0;
			rem_q   <= '0;
		end else begin
			if (cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cnt_dec) begin
				count_q <= cnt_m1;
			end
			if (start_disp) begin
				busy_q <= 1'b1;
				rem_q  <= count_q;
			end else if (step) begin
				rem_q <= rem_q - CW'(1);
				if (rem_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step || emit_status) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (step) begin
			element_q <= cell_val[0];
			status_q  <= ST_OK;
			last_q    <= (rem_q == CW'(1));
		end else if (emit_status) begin
			element_q <= '0;
			status_q  <= emit_code;
			last_q    <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign element   = element_q;
	assign status    = status_q;
	assign last      = last_q;

endmodule

[rtl/core/pli_cell.sv]
// One storage cell of the list chain, holding the element at a fixed index.
module pli_cell #(
	parameter int INDEX = 0
) (
	input  logic               clk,
	input  pli_pkg::cell_ctrl_t ctrl,
	input  pli_pkg::elem_t     left_val,
	input  pli_pkg::elem_t     right_val,
	input  pli_pkg::elem_t     new_val,
	output pli_pkg::elem_t     data
);
	import pli_pkg::*;

	localparam pos_t IDX = POS_W'(INDEX);

	elem_t data_q;

	// Shift, load or wrap the element according to the broadcast command.
	always_ff @(posedge clk) begin
		unique case (ctrl.cmd)
			CMD_HOLD: begin
				data_q <= data_q;
			end
			CMD_INSERT: begin
				if (IDX > ctrl.pos) begin
					data_q <= left_val;
				end else if (IDX == ctrl.pos) begin
					data_q <= new_val;
				end
			end
			CMD_REMOVE: begin
				if (IDX >= ctrl.pos) begin
					data_q <= right_val;
				end
			end
			CMD_ROTATE: begin
				if (IDX == ctrl.last_idx) begin
					data_q <= new_val;
				end else begin
					data_q <= right_val;
				end
			end
			default: begin
				data_q <= data_q;
			end
		endcase
	end

	assign data = data_q;

endmodule

[rtl/core/pli_checker.sv]
// Port-level assertions for the positional list core and their bind.
module pli_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input pli_pkg::elem_t   element,
	input pli_pkg::status_t status,
	input logic             last
);
	import pli_pkg::*;

	// A waiting result item keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(element) && $stable(status)
			&& $stable(last))
		else $error("result item changed while stalled");

	// A status other than ok always ends the item's results.
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> last)
		else $error("error status without last mark");

	// A result with a status other than ok carries a zero element.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> (element == '0))
		else $error("error status with nonzero element");

	// No new item is taken while a display is still running.
	a_disp_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !in_ready)
		else $error("input taken during display");

endmodule

bind positional_list_insert_delete_core pli_checker u_pli_checker (.*);
